// ===== hdl/r2h_pkg.sv =====
package r2h_pkg;

  // Field widths of the pixel and result beats
  localparam int unsigned CompBits    = 8;
  localparam int unsigned SatBits     = 12;
  localparam int unsigned HueFracBits = 6;

  localparam int unsigned LightBits   = CompBits + 1;
  localparam int unsigned HueBits     = HueFracBits + 9;
  localparam int unsigned SectBits    = HueFracBits + 6;

  // One 60 degree sector and the full circle in hue units
  localparam int unsigned Sect        = 60 * (2 ** HueFracBits);
  localparam int unsigned HueWrap     = 6 * Sect;

  // Both dividers retire one quotient bit per stage
  localparam int unsigned DivStages   = (SatBits > SectBits) ? SatBits : SectBits;
  localparam int unsigned HueNumBits  = CompBits + SectBits;
  localparam int unsigned SatNumBits  = CompBits + SatBits;

  localparam logic [CompBits-1:0]  CompFull = '1;
  localparam logic [LightBits-1:0] TwoFull  = {CompFull, 1'b0};

  typedef enum logic [1:0] {
    SectRed,
    SectGreen,
    SectBlue
  } r2h_sect_e;

  typedef struct packed {
    logic      grey;
    logic      neg;
    r2h_sect_e sector;
  } r2h_hside_t;

  typedef struct packed {
    logic [CompBits-1:0] red;
    logic [CompBits-1:0] green;
    logic [CompBits-1:0] blue;
  } r2h_pix_t;

  typedef struct packed {
    logic [HueBits-1:0]   hue;
    logic [SatBits-1:0]   saturation;
    logic [LightBits-1:0] lightness_doubled;
  } r2h_hsl_t;

endpackage

// ===== hdl/r2h_prep.sv =====
module r2h_prep import r2h_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  r2h_pix_t              pix_i,
  output logic                  valid_o,
  output logic [HueNumBits-1:0] hue_num_o,
  output logic [CompBits-1:0]   delta_o,
  output logic [SatNumBits-1:0] sat_num_o,
  output logic [CompBits-1:0]   sat_den_o,
  output r2h_hside_t            side_o,
  output logic [LightBits-1:0]  light_o
);

  // Stage A: extremes, sector and signed hue numerator
  logic                       a_valid_q;
  logic [CompBits-1:0]        mx_q, mn_q, mx_d, mn_d;
  r2h_sect_e                  sect_q, sect_d;
  logic signed [CompBits:0]   num_q, num_d;

  always_comb begin
    mx_d = pix_i.red;
    mn_d = pix_i.red;
    if (pix_i.green > mx_d) mx_d = pix_i.green;
    if (pix_i.blue  > mx_d) mx_d = pix_i.blue;
    if (pix_i.green < mn_d) mn_d = pix_i.green;
    if (pix_i.blue  < mn_d) mn_d = pix_i.blue;
    if (pix_i.red == mx_d) begin
      sect_d = SectRed;
      num_d  = $signed({1'b0, pix_i.green}) - $signed({1'b0, pix_i.blue});
    end else if (pix_i.green == mx_d) begin
      sect_d = SectGreen;
      num_d  = $signed({1'b0, pix_i.blue}) - $signed({1'b0, pix_i.red});
    end else begin
      sect_d = SectBlue;
      num_d  = $signed({1'b0, pix_i.red}) - $signed({1'b0, pix_i.green});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx_q   <= mx_d;
      mn_q   <= mn_d;
      sect_q <= sect_d;
      num_q  <= num_d;
    end
  end

  // Stage B: delta, sum, divisor choice and the two dividends
  logic [CompBits-1:0]   delta_d, den_d, abs_d;
  logic [LightBits-1:0]  sum_d;
  logic [CompBits:0]     absw;
  logic                  neg_d;
  logic [HueNumBits-1:0] hue_num_d;
  logic [SatNumBits-1:0] sat_num_d;
  r2h_hside_t            side_d;

  always_comb begin
    delta_d = mx_q - mn_q;
    sum_d   = {1'b0, mx_q} + {1'b0, mn_q};
    if (sum_d <= {1'b0, CompFull}) begin
      den_d = sum_d[CompBits-1:0];
    end else begin
      den_d = CompBits'(TwoFull - sum_d);
    end
    neg_d     = num_q[CompBits];
    absw      = neg_d ? $unsigned(-num_q) : $unsigned(num_q);
    abs_d     = absw[CompBits-1:0];
    hue_num_d = HueNumBits'(abs_d) * HueNumBits'(Sect);
    // delta * (2^SatBits - 1) as a shift and a subtract
    sat_num_d = {delta_d, {SatBits{1'b0}}} - SatNumBits'(delta_d);
    side_d.grey   = (delta_d == '0);
    side_d.neg    = neg_d;
    side_d.sector = sect_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hue_num_o <= hue_num_d;
      delta_o   <= delta_d;
      sat_num_o <= sat_num_d;
      sat_den_o <= den_d;
      side_o    <= side_d;
      light_o   <= sum_d;
    end
  end

endmodule

// ===== hdl/r2h_div.sv =====
module r2h_div #(
  parameter int unsigned NumW  = 20,
  parameter int unsigned DenW  = 8,
  parameter int unsigned QBits = 12,
  parameter int unsigned SideW = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [QBits-1:0] quo_o,
  output logic [SideW-1:0] side_o
);

  localparam int unsigned CmpW = (NumW > DenW + QBits) ? NumW : DenW + QBits;

  logic             valid_q [QBits];
  logic [QBits-1:0] quo_q   [QBits];
  logic [SideW-1:0] side_q  [QBits];
  logic [NumW-1:0]  rem_q   [QBits-1];
  logic [DenW-1:0]  den_q   [QBits-1];

  // Restoring division, one quotient bit per stage, MSB first
  for (genvar k = 0; k < QBits; k++) begin : g_stage
    logic             valid_in;
    logic [NumW-1:0]  rem_in;
    logic [DenW-1:0]  den_in;
    logic [QBits-1:0] quo_in, quo_d;
    logic [SideW-1:0] side_in;
    logic [CmpW-1:0]  shifted;
    logic             fits;

    if (k == 0) begin : g_first
      assign valid_in = valid_i;
      assign rem_in   = num_i;
      assign den_in   = den_i;
      assign quo_in   = '0;
      assign side_in  = side_i;
    end else begin : g_next
      assign valid_in = valid_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign den_in   = den_q[k-1];
      assign quo_in   = quo_q[k-1];
      assign side_in  = side_q[k-1];
    end

    always_comb begin
      shifted = CmpW'(den_in) << (QBits - 1 - k);
      fits    = CmpW'(rem_in) >= shifted;
      quo_d   = quo_in;
      quo_d[QBits-1-k] = fits;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k]  <= quo_d;
        side_q[k] <= side_in;
      end
    end

    if (k < QBits - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= fits ? NumW'(CmpW'(rem_in) - shifted) : rem_in;
          den_q[k] <= den_in;
        end
      end
    end
  end

  assign valid_o = valid_q[QBits-1];
  assign quo_o   = quo_q[QBits-1];
  assign side_o  = side_q[QBits-1];

endmodule

// ===== hdl/r2h_post.sv =====
module r2h_post import r2h_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [DivStages-1:0] hquo_i,
  input  logic [DivStages-1:0] squo_i,
  input  r2h_hside_t           side_i,
  input  logic [LightBits-1:0] light_i,
  input  logic                 stall_i,
  output logic                 valid_o,
  output r2h_hsl_t             hsl_o,
  output logic                 full_o
);

  logic signed [HueBits+1:0] off, hsum, qext;
  r2h_hsl_t                  res;

  always_comb begin
    case (side_i.sector)
      SectRed:   off = '0;
      SectGreen: off = (HueBits + 2)'(2 * Sect);
      SectBlue:  off = (HueBits + 2)'(4 * Sect);
      default:   off = '0;
    endcase
    qext = $signed({{(HueBits + 2 - SectBits){1'b0}}, hquo_i[SectBits-1:0]});
    hsum = side_i.neg ? off - qext : off + qext;
    // wrap a negative red-sector hue onto the circle
    if (hsum < 0) hsum = hsum + (HueBits + 2)'(HueWrap);
    res.hue               = side_i.grey ? '0 : hsum[HueBits-1:0];
    res.saturation        = side_i.grey ? '0 : squo_i[SatBits-1:0];
    res.lightness_doubled = light_i;
  end

  // Output register plus one skid entry
  logic     out_valid_q, skid_valid_q, push, pop;
  r2h_hsl_t out_q, skid_q;

  assign push = valid_i && !skid_valid_q;
  assign pop  = out_valid_q && !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      out_valid_q  <= skid_valid_q || push;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (push) begin
      skid_q <= res;
    end
  end

  assign valid_o = out_valid_q;
  assign hsl_o   = out_q;
  assign full_o  = skid_valid_q;

endmodule

// ===== hdl/rgb_to_hsl_converter.sv =====
// RGB to HSL converter, one pixel per clock while in_stall_o is low. Each beat
// on the input carries an 8-bit red, green and blue component (255 is full
// scale); each output beat carries hue in 1/64 degree (0..23039, 0 for grey),
// saturation scaled to 4095 and truncated (0 for grey), and max+min of the
// components as doubled lightness. Every input beat gives exactly one output
// beat, in order. From an accepted input beat to the output register, two
// stages find the extremes, sector and dividends, twelve stages run the hue
// and saturation divisions side by side at one quotient bit per stage, and
// one stage finishes the hue and loads the output register. A one-entry skid
// buffer behind the output register means in_stall_o rises only after the
// output has been stalled with a result waiting and a second one arriving;
// the whole pipeline then holds.
module rgb_to_hsl_converter import r2h_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  r2h_pix_t in_pix_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output r2h_hsl_t out_hsl_o
);

  localparam int unsigned HSideW = $bits(r2h_hside_t);

  // Global advance: the whole pipeline moves unless the skid entry is taken
  logic en, full;

  assign en         = !full;
  assign in_stall_o = full;

  logic                  p_valid;
  logic [HueNumBits-1:0] p_hue_num;
  logic [CompBits-1:0]   p_delta;
  logic [SatNumBits-1:0] p_sat_num;
  logic [CompBits-1:0]   p_sat_den;
  r2h_hside_t            p_side;
  logic [LightBits-1:0]  p_light;

  r2h_prep u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_valid_i),
    .pix_i     (in_pix_i),
    .valid_o   (p_valid),
    .hue_num_o (p_hue_num),
    .delta_o   (p_delta),
    .sat_num_o (p_sat_num),
    .sat_den_o (p_sat_den),
    .side_o    (p_side),
    .light_o   (p_light)
  );

  // Hue: |numerator| * Sect / delta, with sector and sign riding along
  logic                 h_valid;
  logic [DivStages-1:0] h_quo;
  logic [HSideW-1:0]    h_side;

  r2h_div #(
    .NumW  (HueNumBits),
    .DenW  (CompBits),
    .QBits (DivStages),
    .SideW (HSideW)
  ) u_hue_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p_valid),
    .num_i   (p_hue_num),
    .den_i   (p_delta),
    .side_i  (p_side),
    .valid_o (h_valid),
    .quo_o   (h_quo),
    .side_o  (h_side)
  );

  // Saturation: delta * 4095 / (sum or 2F - sum), lightness riding along
  logic                 s_valid;
  logic [DivStages-1:0] s_quo;
  logic [LightBits-1:0] s_light;

  r2h_div #(
    .NumW  (SatNumBits),
    .DenW  (CompBits),
    .QBits (DivStages),
    .SideW (LightBits)
  ) u_sat_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p_valid),
    .num_i   (p_sat_num),
    .den_i   (p_sat_den),
    .side_i  (p_light),
    .valid_o (s_valid),
    .quo_o   (s_quo),
    .side_o  (s_light)
  );

  r2h_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (h_valid && s_valid),
    .hquo_i  (h_quo),
    .squo_i  (s_quo),
    .side_i  (r2h_hside_t'(h_side)),
    .light_i (s_light),
    .stall_i (out_stall_i),
    .valid_o (out_valid_o),
    .hsl_o   (out_hsl_o),
    .full_o  (full)
  );

  // The two division pipelines must stay in lockstep
  assert property (@(posedge clk_i) disable iff (!rst_ni) h_valid == s_valid)
    else $error("hue and saturation dividers out of step");

  // The skid entry fills only behind a waiting output beat
  assert property (@(posedge clk_i) disable iff (!rst_ni) full |-> out_valid_o)
    else $error("skid entry taken while output register empty");

  // Hue always lands inside one turn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_hsl_o.hue < HueBits'(HueWrap)))
    else $error("hue beyond full circle");

  // Nonzero saturation cannot come from black or white
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_hsl_o.saturation != '0) |->
      (out_hsl_o.lightness_doubled != '0 && out_hsl_o.lightness_doubled != TwoFull))
    else $error("saturation set on black or white pixel");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import r2h_pkg::*;

  // Clock and reset. Reset starts asserted so every input is known from time zero.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Pixel side (we drive) and HSL side (we sample).
  logic     pix_valid = 1'b0;
  logic     pix_stall;
  r2h_pix_t pix       = '0;
  logic     hsl_valid;
  logic     hsl_stall = 1'b0;
  r2h_hsl_t hsl;

  rgb_to_hsl_converter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_valid),
    .in_stall_o  (pix_stall),
    .in_pix_i    (pix),
    .out_valid_o (hsl_valid),
    .out_stall_i (hsl_stall),
    .out_hsl_o   (hsl)
  );

  // Pixels waiting to be offered, and HSL results owed by the block in order.
  r2h_pix_t pix_pending[$];
  r2h_hsl_t hsl_expected[$];
  int       errors    = 0;
  bit       calm      = 1'b0;  // suppress random gaps on both sides
  bit       hold_armed = 1'b0; // start the long output hold-off
  logic     long_hold = 1'b0;

  // Compute the HSL result of one pixel in plain integer arithmetic.
  // SystemVerilog signed division truncates toward zero, as the hue needs.
  function automatic r2h_hsl_t hsl_of(r2h_pix_t p);
    int r, g, b, mx, mn, delta, sum, span, num, offs, hue, sat;
    int sect_w, wrap_w, comp_full, sat_full;
    r2h_hsl_t res;
    sect_w    = Sect;
    wrap_w    = HueWrap;
    comp_full = (1 << CompBits) - 1;
    sat_full  = (1 << SatBits) - 1;
    r = p.red;
    g = p.green;
    b = p.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    sum   = mx + mn;
    if (delta == 0) begin
      // Grey, black and white included: no hue, no saturation.
      hue = 0;
      sat = 0;
    end else begin
      // Divide by the distance of the sum from the nearer end of its range.
      span = (sum <= comp_full) ? sum : 2 * comp_full - sum;
      sat  = (delta * sat_full) / span;
      if (sat > sat_full) sat = sat_full;
      // Pick the sector of the largest component; red wins ties, then green.
      if (r == mx) begin
        num  = g - b;
        offs = 0;
      end else if (g == mx) begin
        num  = b - r;
        offs = 2 * sect_w;
      end else begin
        num  = r - g;
        offs = 4 * sect_w;
      end
      hue = offs + (num * sect_w) / delta;
      // Wrap a negative red-sector hue onto the full circle.
      if (hue < 0) hue += wrap_w;
    end
    res.hue               = HueBits'(hue);
    res.saturation        = SatBits'(sat);
    res.lightness_doubled = LightBits'(sum);
    return res;
  endfunction

  // Draw an idle length: mostly none, some short, a few long.
  function automatic int idle_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 70) return 0;
    if (k < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int clamp_comp(int v);
    if (v < 0) return 0;
    if (v > (1 << CompBits) - 1) return (1 << CompBits) - 1;
    return v;
  endfunction

  // Random pixel biased toward grey, ties, rails and near-grey colors,
  // where the sector choice and the divisions are most fragile.
  function automatic r2h_pix_t random_pixel();
    int k, r, g, b;
    r2h_pix_t p;
    k = $urandom_range(0, 99);
    r = $urandom_range(0, 255);
    g = $urandom_range(0, 255);
    b = $urandom_range(0, 255);
    if (k < 10) begin
      g = r;
      b = r;
    end else if (k < 25) begin
      case ($urandom_range(0, 2))
        0: g = r;
        1: b = g;
        default: b = r;
      endcase
    end else if (k < 35) begin
      if ($urandom_range(0, 2) == 0) r = $urandom_range(0, 1) * 255;
      if ($urandom_range(0, 2) == 0) g = $urandom_range(0, 1) * 255;
      if ($urandom_range(0, 2) == 0) b = $urandom_range(0, 1) * 255;
    end else if (k < 45) begin
      g = clamp_comp(r + $urandom_range(0, 4) - 2);
      b = clamp_comp(r + $urandom_range(0, 4) - 2);
    end
    p.red   = CompBits'(r);
    p.green = CompBits'(g);
    p.blue  = CompBits'(b);
    return p;
  endfunction

  task automatic queue_pix(int r, int g, int b);
    r2h_pix_t p;
    p.red   = CompBits'(r);
    p.green = CompBits'(g);
    p.blue  = CompBits'(b);
    pix_pending.push_back(p);
  endtask

  // Hold the sender until every queued pixel is in and every result is out,
  // then step to the falling edge so new pushes never race the driver.
  task automatic wait_drained();
    while (pix_pending.size() != 0 || pix_valid || hsl_expected.size() != 0)
      @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Driver: predict the accepted beat, hold a stalled beat, otherwise idle
  // for the drawn gap or launch the next pending pixel.
  int pix_gap = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_valid <= 1'b0;
      pix       <= '0;
      pix_gap   = 0;
    end else begin
      if (pix_valid && !pix_stall) hsl_expected.push_back(hsl_of(pix));
      if (pix_valid && pix_stall) begin
        // hold the beat unchanged
      end else if (pix_gap > 0) begin
        pix_gap--;
        pix_valid <= 1'b0;
      end else if (pix_pending.size() != 0) begin
        pix       <= pix_pending.pop_front();
        pix_valid <= 1'b1;
        pix_gap   = calm ? 0 : idle_len();
      end else begin
        pix_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted result beat against the oldest prediction,
  // then draw the stall for the next cycle.
  int       hsl_gap = 0;
  r2h_hsl_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hsl_stall <= 1'b0;
      hsl_gap   = 0;
    end else begin
      if (hsl_valid && !hsl_stall) begin
        if (hsl_expected.size() == 0) begin
          $error("result beat with nothing expected: hue %0d sat %0d light %0d",
                 hsl.hue, hsl.saturation, hsl.lightness_doubled);
          errors++;
        end else begin
          want = hsl_expected.pop_front();
          if (hsl.hue !== want.hue) begin
            $error("hue: expected %0d, got %0d", want.hue, hsl.hue);
            errors++;
          end
          if (hsl.saturation !== want.saturation) begin
            $error("saturation: expected %0d, got %0d", want.saturation, hsl.saturation);
            errors++;
          end
          if (hsl.lightness_doubled !== want.lightness_doubled) begin
            $error("lightness_doubled: expected %0d, got %0d",
                   want.lightness_doubled, hsl.lightness_doubled);
            errors++;
          end
        end
      end
      if (hsl_gap > 0) hsl_gap--;
      else if (!calm) hsl_gap = idle_len();
      hsl_stall <= long_hold || (hsl_gap > 0);
    end
  end

  // Long hold-off on the result side while pixels keep coming, so the
  // pipeline and skid buffer fill and the block stalls its input.
  initial begin
    while (!hold_armed) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    long_hold <= 1'b1;
    repeat (200) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  // Stimulus: directed corners, then random phases with and without idling.
  initial begin
    while (!rst_ni) @(posedge clk_i);
    @(negedge clk_i);

    queue_pix(0, 0, 0);       // black
    queue_pix(255, 255, 255); // white
    queue_pix(128, 128, 128); // mid grey
    queue_pix(255, 0, 0);     // pure red, sum at full scale
    queue_pix(0, 255, 0);     // pure green
    queue_pix(0, 0, 255);     // pure blue
    queue_pix(255, 255, 0);   // red and green tie: red sector wins
    queue_pix(0, 255, 255);   // green and blue tie: green sector wins
    queue_pix(255, 0, 255);   // red and blue tie: negative hue wraps
    queue_pix(255, 0, 1);     // red sector, small negative hue
    queue_pix(1, 0, 0);       // smallest sum, saturation at maximum
    queue_pix(0, 0, 1);       // blue sector, tiny delta
    queue_pix(255, 254, 254); // sum near top, divisor of one
    queue_pix(254, 255, 255); // green and blue tie near white
    queue_pix(128, 127, 127); // sum just at full scale
    queue_pix(129, 128, 127); // sum just above full scale
    queue_pix(100, 20, 50);   // low lightness, red sector
    queue_pix(255, 128, 200); // high lightness, red sector, negative wrap
    queue_pix(170, 85, 0);    // orange
    queue_pix(90, 200, 40);   // green sector, negative offset within it
    queue_pix(90, 60, 210);   // blue sector, positive offset
    queue_pix(60, 90, 210);   // blue sector, negative offset
    wait_drained();

    // Random phase with the long output hold-off in the middle of it.
    repeat (900) pix_pending.push_back(random_pixel());
    hold_armed = 1'b1;
    wait_drained();

    // Back-to-back stretch with no idling on either side.
    calm = 1'b1;
    repeat (300) pix_pending.push_back(random_pixel());
    wait_drained();

    calm = 1'b0;
    repeat (730) pix_pending.push_back(random_pixel());
    wait_drained();

    // Let the pipeline settle so a stray extra beat would still be caught.
    repeat (40) @(posedge clk_i);
    if (errors == 0 && hsl_expected.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Timeout well beyond the slowest correct run.
  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
